[design/ppf_pkg.sv]
package ppf_pkg;

	// Window geometry
	localparam int WINDOW_SAMPLES = 1024;
	localparam int IDX_W          = $clog2(WINDOW_SAMPLES);
	localparam int LEN_W          = $clog2(WINDOW_SAMPLES + 1);

	// Field widths
	localparam int SAMPLE_W   = 12;
	localparam int LEVEL_W    = 16;
	localparam int MINW_W     = 11;
	localparam int POS_W      = 10;
	localparam int ORD_W      = 9;
	localparam int AMP_W      = LEVEL_W + 2;   // signed baseline - 16*sample
	localparam int CMP_W      = (LEN_W > MINW_W) ? LEN_W : MINW_W;

	localparam logic [ORD_W-1:0] ORD_MAX = '1;

	// Configuration port
	localparam int DATA_W = 32;
	localparam int ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_BASELINE  = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_MIN_WIDTH = 2'd2
	} reg_idx_t;

	// Reset values; threshold is 2.0 counts in sixteenths
	localparam logic [LEVEL_W-1:0] BASELINE_RST  = '0;
	localparam logic [LEVEL_W-1:0] THRESHOLD_RST = LEVEL_W'(32);
	localparam logic [MINW_W-1:0]  MIN_WIDTH_RST = MINW_W'(3);

	typedef struct packed {
		logic [LEVEL_W-1:0] baseline;
		logic [LEVEL_W-1:0] threshold;
		logic [MINW_W-1:0]  min_width;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]   position;
		logic [LEVEL_W-1:0] height;
		logic [ORD_W-1:0]   ordinal;
		logic               window_end;
	} peak_t;

endpackage

[design/ppf_cfg.sv]
module ppf_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ppf_pkg::ADDR_W-1:0]  paddr,
	input  logic [ppf_pkg::DATA_W-1:0]  pwdata,
	output logic [ppf_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output ppf_pkg::cfg_t               cfg
);

	logic [ppf_pkg::LEVEL_W-1:0] baseline_q;
	logic [ppf_pkg::LEVEL_W-1:0] threshold_q;
	logic [ppf_pkg::MINW_W-1:0]  min_width_q;
	logic                        wr_en;
	ppf_pkg::reg_idx_t           reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = ppf_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baseline_q  <= ppf_pkg::BASELINE_RST;
			threshold_q <= ppf_pkg::THRESHOLD_RST;
			min_width_q <= ppf_pkg::MIN_WIDTH_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				ppf_pkg::REG_BASELINE:  baseline_q  <= pwdata[ppf_pkg::LEVEL_W-1:0];
				ppf_pkg::REG_THRESHOLD: threshold_q <= pwdata[ppf_pkg::LEVEL_W-1:0];
				ppf_pkg::REG_MIN_WIDTH: min_width_q <= pwdata[ppf_pkg::MINW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ppf_pkg::REG_BASELINE:  prdata = ppf_pkg::DATA_W'(baseline_q);
			ppf_pkg::REG_THRESHOLD: prdata = ppf_pkg::DATA_W'(threshold_q);
			ppf_pkg::REG_MIN_WIDTH: prdata = ppf_pkg::DATA_W'(min_width_q);
			default:                prdata = '0;
		endcase
	end

	assign cfg.baseline  = baseline_q;
	assign cfg.threshold = threshold_q;
	assign cfg.min_width = min_width_q;

endmodule

[design/ppf_detect.sv]
module ppf_detect (
	input  logic            clk,
	input  logic            arst_n,
	input  ppf_pkg::cfg_t   cfg,
	input  ppf_pkg::item_t  item,
	input  logic            item_valid,
	input  logic            out_free,
	output logic            advance,
	output logic            report,
	output ppf_pkg::peak_t  peak
);

	localparam int IDX_W = ppf_pkg::IDX_W;
	localparam int LEN_W = ppf_pkg::LEN_W;
	localparam int AMP_W = ppf_pkg::AMP_W;

	// window / pulse state
	logic [IDX_W-1:0]            sample_index_q;
	logic                        in_pulse_q;
	logic [IDX_W-1:0]            pulse_start_q;
	logic [ppf_pkg::LEVEL_W-1:0] max_amp_q;
	logic [IDX_W-1:0]            max_index_q;
	logic [ppf_pkg::ORD_W-1:0]   pulse_count_q;

	logic signed [AMP_W-1:0]     amp;
	logic                        above;
	logic                        last;
	logic                        opening;
	logic                        closing;
	logic                        new_max;
	logic [IDX_W-1:0]            nxt_start;
	logic [ppf_pkg::LEVEL_W-1:0] nxt_max_amp;
	logic [IDX_W-1:0]            nxt_max_index;
	logic [LEN_W-1:0]            len;
	logic                        long_enough;

	assign amp = $signed(AMP_W'(cfg.baseline)) -
	             $signed(AMP_W'({item.sample, 4'b0000}));
	assign above = amp > $signed(AMP_W'(cfg.threshold));
	assign last  = item.last || (sample_index_q == IDX_W'(ppf_pkg::WINDOW_SAMPLES - 1));

	assign opening = above && !in_pulse_q;
	assign closing = !above && in_pulse_q;
	// amp is positive whenever above is set, so its low bits are the height
	assign new_max = above && (opening || (amp > $signed(AMP_W'(max_amp_q))));

	assign nxt_start     = opening ? sample_index_q : pulse_start_q;
	assign nxt_max_amp   = new_max ? amp[ppf_pkg::LEVEL_W-1:0] : max_amp_q;
	assign nxt_max_index = new_max ? sample_index_q : max_index_q;

	// below-threshold close excludes the closing sample; end-of-window close includes it
	assign len = closing ? (LEN_W'(sample_index_q) - LEN_W'(pulse_start_q))
	                     : (LEN_W'(sample_index_q) + LEN_W'(1) - LEN_W'(nxt_start));
	assign long_enough = ppf_pkg::CMP_W'(len) >= ppf_pkg::CMP_W'(cfg.min_width);

	assign report  = item_valid && (closing || (above && last)) && long_enough;
	assign advance = item_valid && (!report || out_free);

	assign peak.position   = ppf_pkg::POS_W'(nxt_max_index);
	assign peak.height     = nxt_max_amp;
	assign peak.ordinal    = pulse_count_q;
	assign peak.window_end = !closing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q <= '0;
			in_pulse_q     <= 1'b0;
			pulse_start_q  <= '0;
			max_amp_q      <= '0;
			max_index_q    <= '0;
			pulse_count_q  <= '0;
		end else if (advance) begin
			if (last) begin
				sample_index_q <= '0;
				in_pulse_q     <= 1'b0;
				pulse_start_q  <= '0;
				max_amp_q      <= '0;
				max_index_q    <= '0;
				pulse_count_q  <= '0;
			end else begin
				sample_index_q <= sample_index_q + IDX_W'(1);
				in_pulse_q     <= above;
				pulse_start_q  <= nxt_start;
				max_amp_q      <= nxt_max_amp;
				max_index_q    <= nxt_max_index;
				if (report && (pulse_count_q != ppf_pkg::ORD_MAX)) begin
					pulse_count_q <= pulse_count_q + ppf_pkg::ORD_W'(1);
				end
			end
		end
	end

endmodule

[design/ppf_out_reg.sv]
module ppf_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  ppf_pkg::peak_t  peak_in,
	input  logic            out_stall,
	output logic            out_valid,
	output ppf_pkg::peak_t  peak_out,
	output logic            free
);

	logic           valid_q;
	ppf_pkg::peak_t peak_q;

	// slot can take a new beat when empty or being drained this cycle
	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			peak_q <= peak_in;
		end
	end

	assign out_valid = valid_q;
	assign peak_out  = peak_q;

endmodule

[design/pulse_peak_finder_top.sv]
// Pulse peak finder.
// Input channel (in_valid / in_stall): one digitizer sample per beat, with
// window_last marking the final sample of a window. Amplitude is
// baseline_level - 16*sample in sixteenths of a count; a pulse is a run of
// samples above amp_threshold. For each pulse lasting at least min_width
// samples one output beat carries the index of its first highest sample,
// that height, its ordinal within the window and window_end.
// Output channel (out_valid / out_stall): zero or one beat per input beat.
// Pipeline: a sample is registered in the input register on acceptance and
// evaluated against the pulse state; its result loads the output register as it advances.
// Throughput: one sample per clock while in_stall is low, with the single
// compare/update stage between the input register and the result register.
// Stall: a result waiting in the output register does not block samples that
// produce no result; in_stall rises only when a new result is ready and the
// output register is still held by out_stall.
// Reset (arst_n low): registers return to baseline 0, threshold 32, min width
// 3; the window index, pulse state and ordinal count clear; both valids drop.
// The APB port is always ready; the user must write registers only while idle (not enforced).
module pulse_peak_finder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppf_pkg::ADDR_W-1:0]    paddr,
	input  logic [ppf_pkg::DATA_W-1:0]    pwdata,
	output logic [ppf_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ppf_pkg::SAMPLE_W-1:0]  sample,
	input  logic                          window_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ppf_pkg::POS_W-1:0]     peak_position,
	output logic [ppf_pkg::LEVEL_W-1:0]   peak_height,
	output logic [ppf_pkg::ORD_W-1:0]     peak_ordinal,
	output logic                          window_end
);

	ppf_pkg::cfg_t  cfg;
	ppf_pkg::item_t item_s1;
	logic           valid_s1;
	logic           in_accept;
	logic           advance;
	logic           report;
	logic           out_free;
	ppf_pkg::peak_t peak_new;
	ppf_pkg::peak_t peak_out;

	ppf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register: holds one sample until the detect stage consumes it.
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.sample <= sample;
			item_s1.last   <= window_last;
		end
	end

	ppf_detect u_detect (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item       (item_s1),
		.item_valid (valid_s1),
		.out_free   (out_free),
		.advance    (advance),
		.report     (report),
		.peak       (peak_new)
	);

	ppf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (report && advance),
		.peak_in   (peak_new),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.peak_out  (peak_out),
		.free      (out_free)
	);

	assign peak_position = peak_out.position;
	assign peak_height   = peak_out.height;
	assign peak_ordinal  = peak_out.ordinal;
	assign window_end    = peak_out.window_end;

endmodule

[design/ppf_checker.sv]
module ppf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [ppf_pkg::POS_W-1:0]     peak_position,
	input logic [ppf_pkg::LEVEL_W-1:0]   peak_height,
	input logic [ppf_pkg::ORD_W-1:0]     peak_ordinal,
	input logic                          window_end
);

	// input backs up only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a held output beat");

	// a fresh result comes from an earlier accepted sample
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a matching input beat");

	// a reported pulse lies strictly above a non-negative threshold
	a_height_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (peak_height != '0))
		else $error("zero peak height reported");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(peak_position)
			&& $stable(peak_height) && $stable(peak_ordinal) && $stable(window_end)))
		else $error("stalled output beat changed");

endmodule

bind pulse_peak_finder_top ppf_checker u_ppf_checker (.*);
